/* rtl/core/decimal_text_byte_converter_assert.svh */
// assertion macros used by the converter checker
`ifndef DECIMAL_TEXT_BYTE_CONVERTER_ASSERT_SVH
`define DECIMAL_TEXT_BYTE_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DTB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter check failed");

// next-cycle implication, sampled on clk, off while in reset
`define DTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter check failed");

`endif

/* rtl/core/dtb_pkg.sv */
// types, constants and helpers shared by the decimal text converter
package dtb_pkg;

    localparam logic [7:0] CH_MINUS       = 8'd45;
    localparam logic [7:0] CH_ZERO        = 8'd48;
    localparam logic [7:0] CH_DIGIT_BELOW = 8'd47;
    localparam logic [7:0] CH_DIGIT_ABOVE = 8'd58;
    localparam logic [7:0] SEP_DEFAULT    = 8'd95;
    localparam int         TEXT_MAX       = 5;

    typedef enum logic [1:0] {
        REG_DIRECTION     = 2'd0,
        REG_SIGNED_FORMAT = 2'd1,
        REG_SEPARATOR     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_error;
        logic       out_last;
    } out_word_t;

    typedef struct packed {
        logic       direction;
        logic       signed_format;
        logic [7:0] separator;
    } cfg_t;

    // one queued job: up to five characters, index of the last one
    typedef struct packed {
        logic [TEXT_MAX-1:0][7:0] text;
        logic [2:0]               last_idx;
        logic                     error;
    } job_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c > CH_DIGIT_BELOW) && (c < CH_DIGIT_ABOVE);
    endfunction

endpackage

/* rtl/core/dtb_queue.sv */
// small job queue between the front and back parts
module dtb_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dtb_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output dtb_pkg::job_t head
);
    import dtb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/core/dtb_front.sv */
// front part: accepts words, tracks the token, builds output jobs
module dtb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  dtb_pkg::in_word_t in_data,
    input  dtb_pkg::cfg_t     cfg,
    input  logic              q_full,
    output logic              in_stall,
    output logic              push,
    output dtb_pkg::job_t     job
);
    import dtb_pkg::*;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       negative;
        logic       nonempty;
        logic       has_digit;
        logic       malformed;
        logic       overflow;
    } tok_t;

    tok_t tok_reg, tok_next;

    function automatic tok_t add_char(input tok_t t, input logic [7:0] c);
        tok_t        r;
        logic [11:0] v;
        r = t;
        v = 12'(t.magnitude) * 12'd10 + 12'(c - CH_ZERO);
        if (c == CH_MINUS)
        begin
            if (t.nonempty)
                r.malformed = 1'b1;
            else
                r.negative = 1'b1;
        end
        else
        begin
            if (v > 12'd255)
            begin
                r.magnitude = 8'd255;
                r.overflow  = 1'b1;
            end
            else
            begin
                r.magnitude = v[7:0];
            end
            r.has_digit = 1'b1;
        end
        r.nonempty = 1'b1;
        return r;
    endfunction

    function automatic job_t close_token(input tok_t t);
        job_t       j;
        logic [7:0] limit;
        logic       bad;
        j     = '0;
        limit = t.negative ? 8'd128 : 8'd127;
        bad   = !t.nonempty || !t.has_digit || t.malformed || t.overflow ||
                (t.magnitude > limit);
        j.error   = bad;
        j.text[0] = bad ? 8'd0 : (t.negative ? (~t.magnitude + 8'd1) : t.magnitude);
        return j;
    endfunction

    logic       accept, is_num;
    logic [7:0] c;
    tok_t       tok_add;
    job_t       fmt_job;
    logic [7:0] mag;
    logic [1:0] d2;
    logic [7:0] rem8;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [3:0] d1;
    logic [6:0] d0w;
    logic [2:0] n;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign c        = in_data.in_byte;
    assign is_num   = (c == CH_MINUS) || is_digit(c);
    assign tok_add  = add_char(tok_reg, c);

    // split the byte into decimal digits, no divider needed
    always_comb
    begin
        mag  = (cfg.signed_format && c[7]) ? (~c + 8'd1) : c;
        d2   = (mag >= 8'd200) ? 2'd2 : ((mag >= 8'd100) ? 2'd1 : 2'd0);
        rem8 = mag - ((d2 == 2'd2) ? 8'd200 : ((d2 == 2'd1) ? 8'd100 : 8'd0));
        rem  = rem8[6:0];
        prod = 15'(rem) * 15'd205;
        d1   = prod[14:11];
        d0w  = rem - 7'(d1) * 7'd10;
    end

    // pack sign, digits and separator in order
    always_comb
    begin
        fmt_job = '0;
        n       = '0;
        if (cfg.signed_format && c[7])
        begin
            fmt_job.text[n] = CH_MINUS;
            n = n + 3'd1;
        end
        if (d2 != 2'd0)
        begin
            fmt_job.text[n] = CH_ZERO + 8'(d2);
            n = n + 3'd1;
        end
        if (d2 != 2'd0 || d1 != 4'd0)
        begin
            fmt_job.text[n] = CH_ZERO + 8'(d1);
            n = n + 3'd1;
        end
        fmt_job.text[n] = CH_ZERO + 8'(d0w[3:0]);
        n = n + 3'd1;
        if (!in_data.in_last)
        begin
            fmt_job.text[n] = cfg.separator;
            n = n + 3'd1;
        end
        fmt_job.last_idx = n - 3'd1;
    end

    always_comb
    begin
        tok_next = tok_reg;
        push     = 1'b0;
        job      = fmt_job;
        if (cfg.direction)
        begin
            push = accept;
        end
        else if (is_num)
        begin
            job = close_token(tok_add);
            if (accept)
            begin
                push     = in_data.in_last;
                tok_next = in_data.in_last ? '0 : tok_add;
            end
        end
        else
        begin
            job = close_token(tok_reg);
            if (accept)
            begin
                push     = 1'b1;
                tok_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

endmodule

/* rtl/core/dtb_back.sv */
// back part: walks the head job one character a cycle into the output register
module dtb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  dtb_pkg::job_t      head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output dtb_pkg::out_word_t out_data
);
    import dtb_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_reg, out_next;
    logic       slot_free, emit, at_last;

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit      = slot_free && not_empty;
    assign at_last   = (idx_reg == head.last_idx);
    assign pop       = emit && at_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next.out_byte  = head.text[idx_reg];
            out_next.out_error = head.error;
            out_next.out_last  = at_last;
            out_valid_next     = 1'b1;
            idx_next           = at_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* rtl/core/decimal_text_byte_converter.sv */
// top level of the decimal text to byte converter
// with the queue empty, a pushed job is registered in the queue and its first character
// then in the output register; throughput: parse mode takes one word per cycle unless
// in_stall; format mode emits 1 to 5 characters a word, one per cycle unless out_stall,
// set by the single output register stage
// a queue of QUEUE_DEPTH jobs lets the input run ahead of the output
// reset (rst_n low, async): token cleared, queue empty, config registers to defaults
module decimal_text_byte_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dtb_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output dtb_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import dtb_pkg::*;

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // queue hookup between front and back
    logic q_full, q_not_empty, q_push, q_pop;
    job_t q_in_job, q_head;

    // config writes always taken; user writes only while the block is idle; not enforced
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIRECTION:     cfg_next.direction     = cfg_data[0];
                REG_SIGNED_FORMAT: cfg_next.signed_format = cfg_data[0];
                REG_SEPARATOR:
                begin
                    // minus sign and digits would be ambiguous as separator
                    if (cfg_data != CH_MINUS && !is_digit(cfg_data))
                        cfg_next.separator = cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction     <= 1'b0;
            cfg_reg.signed_format <= 1'b1;
            cfg_reg.separator     <= SEP_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify the word, update token, build a job
    dtb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (q_push),
        .job      (q_in_job)
    );

    // queue decouples input acceptance from output stalls
    dtb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: one output word per cycle from the head job unless out_stall holds it
    dtb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/dtb_checker.sv */
// port-level checks for the converter, bound to the top level
`include "decimal_text_byte_converter_assert.svh"

module dtb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input dtb_pkg::out_word_t out_data
);
    import dtb_pkg::*;

    // a stalled output word holds
    `DTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // an error result is a single zero word
    `DTB_ASSERT_NOW(a_err_zero, out_valid && out_data.out_error,
                    out_data.out_byte == 8'd0 && out_data.out_last)

    // characters of one word follow each other without gaps
    `DTB_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !out_data.out_last, out_valid)

endmodule

bind decimal_text_byte_converter dtb_checker u_dtb_checker (.*);
